@@ rtl/mccp_pkg.sv @@
// Shared constants and types for the motor command console parser.
// No dependencies; used by the parser top level and its port checker.
package mccp_pkg;

  localparam int unsigned ENTRY_W   = 17;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned PRODUCT_W = 21;

  localparam logic [ENTRY_W-1:0] VALUE_MAX = 17'h1FFFF;

  // console keys
  localparam logic [7:0] KEY_CR       = 8'h0D;
  localparam logic [7:0] KEY_ENABLE   = 8'h31;  // '1'
  localparam logic [7:0] KEY_SETPOINT = 8'h32;  // '2'
  localparam logic [7:0] KEY_DISABLE  = 8'h33;  // '3'
  localparam logic [7:0] KEY_SHOW_ERR = 8'h34;  // '4'
  localparam logic [7:0] KEY_INCR     = 8'h77;  // 'w'
  localparam logic [7:0] KEY_DECR     = 8'h73;  // 's'
  localparam logic [7:0] KEY_DIGIT_LO = 8'h30;  // '0'
  localparam logic [7:0] KEY_DIGIT_HI = 8'h39;  // '9'

  // command bytes to the motor node
  localparam logic [7:0] LINK_ENABLE   = 8'hFF;
  localparam logic [7:0] LINK_DISABLE  = 8'hFE;
  localparam logic [7:0] LINK_SETPOINT = 8'hFD;
  localparam logic [7:0] LINK_INCR     = 8'hFC;
  localparam logic [7:0] LINK_DECR     = 8'hFB;

  typedef enum logic [3:0] {
    MSG_NONE       = 4'd0,
    MSG_STARTED    = 4'd1,
    MSG_PROMPT     = 4'd2,
    MSG_MOTOR_OFF  = 4'd3,
    MSG_STOPPED    = 4'd4,
    MSG_SHOW_ERROR = 4'd5,
    MSG_UNKNOWN    = 4'd6,
    MSG_SYNTAX     = 4'd7,
    MSG_TOO_HIGH   = 4'd8
  } msg_t;

  // register byte addresses
  localparam logic [2:0] ADDR_SETPOINT_LIMIT = 3'd0;
  localparam logic [7:0] SETPOINT_LIMIT_RST  = 8'd100;

endpackage

@@ rtl/motor_command_console_parser.sv @@
// Motor command console parser: one console byte in, one result beat out.
// Depends on mccp_pkg.
//
// Takes one received console byte per input beat and returns exactly one
// result beat for it, carrying an optional command byte for the motor node
// and a message code. Keys 1, 2, 3, 4, w and s mean enable, set point,
// disable, show error, increment and decrement; set point needs the motor on
// and opens decimal entry, which a carriage return closes when the value is
// clean and within setpoint_limit (value sent), else syntax or too-high is
// reported and entry stays open. Every byte is decoded in the cycle it is
// accepted and its result sits in the output register the next cycle: one
// byte per clock sustained while the sink keeps up. The input is stalled only
// while that output register holds a beat the sink has not taken. setpoint_limit
// (byte address 0) should be written only while no beat is in flight.
module motor_command_console_parser #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst,
  // console input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] link_valid, [8:1] link_byte, [12:9] message
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [mccp_pkg::COUNT_W-1:0] DIGIT_LIMIT = mccp_pkg::COUNT_W'(MAX_DIGITS);

  logic [7:0] setpoint_limit;

  logic                          motor_on, motor_on_next;
  logic                          entry_mode, entry_mode_next;
  logic [mccp_pkg::ENTRY_W-1:0]  entry_value, entry_value_next;
  logic [mccp_pkg::COUNT_W-1:0]  digit_count, digit_count_next;
  logic                          bad_entry, bad_entry_next;

  logic                          link_valid, link_valid_next;
  logic [7:0]                    link_byte, link_byte_next;
  mccp_pkg::msg_t                message, message_next;

  logic                          accept;
  logic [7:0]                    rx_byte;
  logic                          is_digit;
  logic [mccp_pkg::PRODUCT_W-1:0] product;

  assign rx_byte  = s_tdata;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == mccp_pkg::ADDR_SETPOINT_LIMIT) ? {24'd0, setpoint_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_limit <= mccp_pkg::SETPOINT_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      setpoint_limit <= pwdata[7:0];
    end
  end

  // value*10 + digit, saturated to the entry width
  assign is_digit = rx_byte inside {[mccp_pkg::KEY_DIGIT_LO:mccp_pkg::KEY_DIGIT_HI]};
  assign product  = ({4'd0, entry_value} << 3) + ({4'd0, entry_value} << 1)
                  + {17'd0, rx_byte[3:0]};

  always_comb begin
    motor_on_next    = motor_on;
    entry_mode_next  = entry_mode;
    entry_value_next = entry_value;
    digit_count_next = digit_count;
    bad_entry_next   = bad_entry;
    link_valid_next  = 1'b0;
    link_byte_next   = 8'd0;
    message_next     = mccp_pkg::MSG_NONE;

    if (entry_mode) begin
      if (rx_byte != mccp_pkg::KEY_CR) begin
        if (digit_count < DIGIT_LIMIT) begin
          if (is_digit) begin
            entry_value_next = (product > {4'd0, mccp_pkg::VALUE_MAX}) ?
                               mccp_pkg::VALUE_MAX : product[mccp_pkg::ENTRY_W-1:0];
          end else begin
            bad_entry_next = 1'b1;
          end
          digit_count_next = digit_count + 1'b1;
        end else begin
          bad_entry_next = 1'b1;  // overlong entry
        end
      end else begin
        if (bad_entry) begin
          message_next = mccp_pkg::MSG_SYNTAX;
        end else if (entry_value > {9'd0, setpoint_limit}) begin
          message_next = mccp_pkg::MSG_TOO_HIGH;
        end else begin
          link_valid_next = 1'b1;
          link_byte_next  = entry_value[7:0];
          entry_mode_next = 1'b0;
        end
        entry_value_next = '0;
        digit_count_next = '0;
        bad_entry_next   = 1'b0;
      end
    end else begin
      case (rx_byte)
        mccp_pkg::KEY_ENABLE: begin
          motor_on_next   = 1'b1;
          link_valid_next = 1'b1;
          link_byte_next  = mccp_pkg::LINK_ENABLE;
          message_next    = mccp_pkg::MSG_STARTED;
        end
        mccp_pkg::KEY_SETPOINT: begin
          if (motor_on) begin
            link_valid_next  = 1'b1;
            link_byte_next   = mccp_pkg::LINK_SETPOINT;
            message_next     = mccp_pkg::MSG_PROMPT;
            entry_mode_next  = 1'b1;
            entry_value_next = '0;
            digit_count_next = '0;
            bad_entry_next   = 1'b0;
          end else begin
            message_next = mccp_pkg::MSG_MOTOR_OFF;
          end
        end
        mccp_pkg::KEY_DISABLE: begin
          motor_on_next   = 1'b0;
          link_valid_next = 1'b1;
          link_byte_next  = mccp_pkg::LINK_DISABLE;
          message_next    = mccp_pkg::MSG_STOPPED;
        end
        mccp_pkg::KEY_SHOW_ERR: begin
          message_next = mccp_pkg::MSG_SHOW_ERROR;
        end
        mccp_pkg::KEY_INCR: begin
          link_valid_next = 1'b1;
          link_byte_next  = mccp_pkg::LINK_INCR;
        end
        mccp_pkg::KEY_DECR: begin
          link_valid_next = 1'b1;
          link_byte_next  = mccp_pkg::LINK_DECR;
        end
        default: begin
          message_next = mccp_pkg::MSG_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_on    <= 1'b0;
      entry_mode  <= 1'b0;
      entry_value <= '0;
      digit_count <= '0;
      bad_entry   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        motor_on    <= motor_on_next;
        entry_mode  <= entry_mode_next;
        entry_value <= entry_value_next;
        digit_count <= digit_count_next;
        bad_entry   <= bad_entry_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted byte
  always_ff @(posedge clk) begin
    if (accept) begin
      link_valid <= link_valid_next;
      link_byte  <= link_byte_next;
      message    <= message_next;
    end
  end

  assign m_tdata = {3'd0, message, link_byte, link_valid};

endmodule

@@ rtl/mccp_checker.sv @@
// Port-level checker for the motor command console parser, with its bind.
// Depends on mccp_pkg and motor_command_console_parser.
module mccp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a stalled result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // every accepted byte shows up as a result beat on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted byte produced no result beat");

  // no command byte without link_valid, message codes stay in range, top bits stay zero
  a_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[0] || m_tdata[8:1] == 8'd0)
                  && m_tdata[12:9] <= mccp_pkg::MSG_TOO_HIGH
                  && m_tdata[15:13] == 3'd0))
    else $error("malformed result payload");

  // a waiting input beat stays offered with the same byte
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
    else $error("input beat dropped or changed while stalled");

endmodule

bind motor_command_console_parser mccp_checker u_mccp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ test/tb.sv @@
// Self-checking bench for motor_command_console_parser: console keys in, link/message beats out.
// Depends on mccp_pkg and the parser RTL; an in-bench parser model predicts every result beat.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DIGIT_LIMIT   = 5;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_BYTES  = 1500;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    logic           link_valid;
    logic [7:0]     link_byte;
    mccp_pkg::msg_t message;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [0] link_valid, [8:1] link_byte, [12:9] message
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  motor_command_console_parser #(.MAX_DIGITS(DIGIT_LIMIT)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser shadow state
  logic [7:0]                   setpoint_limit_shadow = mccp_pkg::SETPOINT_LIMIT_RST;
  logic                         motor_running = 1'b0;
  logic                         entry_active = 1'b0;
  logic [mccp_pkg::ENTRY_W-1:0] entry_acc = '0;
  logic [mccp_pkg::COUNT_W-1:0] chars_taken = '0;
  logic                         entry_bad = 1'b0;

  console_result_t     pending_results[$];
  int unsigned         fail_count = 0;
  int unsigned         bytes_sent = 0;
  int unsigned         cycle_count = 0;
  logic                source_calm = 1'b0;
  logic                sink_calm = 1'b0;

  function automatic console_result_t parse_console_byte(input logic [7:0] key);
    console_result_t r;
    int unsigned     acc;
    r = '{1'b0, 8'h00, mccp_pkg::MSG_NONE};
    if (entry_active) begin
      if (key != mccp_pkg::KEY_CR) begin
        if (chars_taken < DIGIT_LIMIT) begin
          if (key >= mccp_pkg::KEY_DIGIT_LO && key <= mccp_pkg::KEY_DIGIT_HI) begin
            acc = entry_acc * 10 + 32'(key - mccp_pkg::KEY_DIGIT_LO);
            entry_acc = (acc > mccp_pkg::VALUE_MAX) ? mccp_pkg::VALUE_MAX
                                                    : acc[mccp_pkg::ENTRY_W-1:0];
          end else begin
            entry_bad = 1'b1;
          end
          chars_taken = chars_taken + 1'b1;
        end else begin
          entry_bad = 1'b1;   // past the digit buffer
        end
      end else begin
        if (entry_bad) begin
          r.message = mccp_pkg::MSG_SYNTAX;
        end else if (entry_acc > setpoint_limit_shadow) begin
          r.message = mccp_pkg::MSG_TOO_HIGH;
        end else begin
          r.link_valid = 1'b1;
          r.link_byte = entry_acc[7:0];
          entry_active = 1'b0;
        end
        entry_acc = '0;
        chars_taken = '0;
        entry_bad = 1'b0;
      end
    end else begin
      case (key)
        mccp_pkg::KEY_ENABLE: begin
          motor_running = 1'b1;
          r = '{1'b1, mccp_pkg::LINK_ENABLE, mccp_pkg::MSG_STARTED};
        end
        mccp_pkg::KEY_SETPOINT: begin
          if (motor_running) begin
            r = '{1'b1, mccp_pkg::LINK_SETPOINT, mccp_pkg::MSG_PROMPT};
            entry_active = 1'b1;
            entry_acc = '0;
            chars_taken = '0;
            entry_bad = 1'b0;
          end else begin
            r.message = mccp_pkg::MSG_MOTOR_OFF;
          end
        end
        mccp_pkg::KEY_DISABLE: begin
          motor_running = 1'b0;
          r = '{1'b1, mccp_pkg::LINK_DISABLE, mccp_pkg::MSG_STOPPED};
        end
        mccp_pkg::KEY_SHOW_ERR: r.message = mccp_pkg::MSG_SHOW_ERROR;
        mccp_pkg::KEY_INCR:     r = '{1'b1, mccp_pkg::LINK_INCR, mccp_pkg::MSG_NONE};
        mccp_pkg::KEY_DECR:     r = '{1'b1, mccp_pkg::LINK_DECR, mccp_pkg::MSG_NONE};
        default:                r.message = mccp_pkg::MSG_UNKNOWN;
      endcase
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic note_mismatch(input string text);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", text);
  endtask

  task automatic send_console_byte(input logic [7:0] key);
    int unsigned gap;
    gap = pick_gap(source_calm);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= key;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(parse_console_byte(key));
    bytes_sent++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_console_byte(text[i]);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= mccp_pkg::ADDR_SETPOINT_LIMIT;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_limit_readback();
    logic [31:0] rd;
    apb_transfer(1'b0, 32'd0, rd);
    if (rd !== 32'(setpoint_limit_shadow))
      note_mismatch($sformatf("setpoint_limit read: expected %0d, got %0d",
                              setpoint_limit_shadow, rd));
  endtask

  task automatic program_limit(input logic [7:0] value);
    logic [31:0] rd;
    wait_idle();
    apb_transfer(1'b1, 32'(value), rd);
    setpoint_limit_shadow = value;
    check_limit_readback();
  endtask

  // result beat checker
  always @(posedge clk) begin
    console_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat %h", m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.link_valid || m_tdata[8:1] !== want.link_byte ||
            m_tdata[12:9] !== want.message)
          note_mismatch($sformatf(
            "result mismatch: expected valid %0b byte %h msg %0d, got valid %0b byte %h msg %0d",
            want.link_valid, want.link_byte, want.message,
            m_tdata[0], m_tdata[8:1], m_tdata[12:9]));
      end
    end
  end

  // sink back-pressure
  initial begin
    int unsigned hold;
    int unsigned r;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!sink_calm && r < 20) hold = (r < 3) ? $urandom_range(5, 24) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic test_register_access();
    check_limit_readback();
    program_limit(8'd0);
    program_limit(8'd255);
    program_limit(mccp_pkg::SETPOINT_LIMIT_RST);
  endtask

  task automatic test_normal_keys();
    send_console_byte(mccp_pkg::KEY_SETPOINT);   // motor still off
    send_console_byte(mccp_pkg::KEY_SHOW_ERR);
    send_console_byte(mccp_pkg::KEY_INCR);
    send_console_byte(mccp_pkg::KEY_DECR);
    send_console_byte(8'h00);
    send_console_byte(8'hFF);
    send_console_byte(mccp_pkg::KEY_ENABLE);
  endtask

  task automatic test_setpoint_entry();
    send_console_byte(mccp_pkg::KEY_SETPOINT);
    send_console_byte(mccp_pkg::KEY_CR);         // empty entry takes zero
    send_console_byte(mccp_pkg::KEY_SETPOINT);
    send_text("101");
    send_console_byte(mccp_pkg::KEY_CR);         // one above the limit
    send_text("100000");
    send_console_byte(mccp_pkg::KEY_CR);         // overlong
    send_text("x");
    send_console_byte(mccp_pkg::KEY_CR);
    send_text("100");
    send_console_byte(mccp_pkg::KEY_CR);
    send_console_byte(mccp_pkg::KEY_DISABLE);
  endtask

  task automatic setpoint_session();
    logic [7:0]  keys[$];
    int unsigned kind;
    int unsigned pos;
    logic [7:0]  junk;
    string       text;
    if (!entry_active) begin
      if (!motor_running) send_console_byte(mccp_pkg::KEY_ENABLE);
      send_console_byte(mccp_pkg::KEY_SETPOINT);
    end
    kind = $urandom_range(0, 9);
    text = "";
    if (kind <= 4) begin
      text = $sformatf("%0d", $urandom_range(0, setpoint_limit_shadow + 10));
      if (kind == 0) text = {"0", text};
    end else if (kind == 9) begin
      text = $sformatf("%0d", $urandom_range(0, 99999));
    end
    for (int i = 0; i < text.len(); i++) keys.push_back(text[i]);
    if (kind == 6) begin
      repeat ($urandom_range(5, 7))
        keys.push_back(8'(mccp_pkg::KEY_DIGIT_LO + $urandom_range(0, 9)));
    end else if (kind == 7 || kind == 8) begin
      repeat ($urandom_range(1, 5))
        keys.push_back(8'(mccp_pkg::KEY_DIGIT_LO + $urandom_range(0, 9)));
      do junk = 8'($urandom_range(0, 255)); while (junk == mccp_pkg::KEY_CR);
      pos = $urandom_range(0, keys.size() - 1);
      keys[pos] = junk;
    end
    foreach (keys[i]) send_console_byte(keys[i]);
    send_console_byte(mccp_pkg::KEY_CR);
    if (entry_active && $urandom_range(0, 3) != 0) send_text("0\r");
  endtask

  task automatic test_random_traffic();
    logic [7:0]  normal_keys[6];
    logic [7:0]  phase_limit[5];
    int unsigned r;
    int unsigned target;
    int unsigned next_shuffle;
    normal_keys = '{mccp_pkg::KEY_ENABLE, mccp_pkg::KEY_SETPOINT, mccp_pkg::KEY_DISABLE,
                    mccp_pkg::KEY_SHOW_ERR, mccp_pkg::KEY_INCR, mccp_pkg::KEY_DECR};
    phase_limit = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), mccp_pkg::SETPOINT_LIMIT_RST,
                    8'($urandom_range(0, 255))};
    foreach (phase_limit[p]) begin
      program_limit(phase_limit[p]);
      target = bytes_sent + RANDOM_BYTES / 5;
      next_shuffle = bytes_sent;
      while (bytes_sent < target) begin
        if (bytes_sent >= next_shuffle) begin
          source_calm = ($urandom_range(0, 3) == 0);
          sink_calm = ($urandom_range(0, 3) == 0);
          next_shuffle = bytes_sent + 100;
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
          setpoint_session();
        end else if (r < 75) begin
          send_console_byte(normal_keys[$urandom_range(0, 5)]);
        end else if (r < 90) begin
          send_console_byte(8'($urandom_range(0, 255)));
        end else begin
          send_console_byte(mccp_pkg::KEY_DISABLE);
          send_console_byte(mccp_pkg::KEY_SETPOINT);
        end
      end
    end
    source_calm = 1'b0;
    sink_calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_register_access();
    test_normal_keys();
    test_setpoint_entry();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mccp_pkg.sv
rtl/motor_command_console_parser.sv
rtl/mccp_checker.sv
test/tb.sv
